/* rtl/ccc_pkg.sv */
// Shared types, constants and helpers for the cable constraint correction block.
// Used by ccc_sqrt, ccc_div and cable_constraint_correction; depends on nothing.
package ccc_pkg;

  localparam int FRAC      = 16;
  localparam int SQ_STEPS  = 33;
  localparam int QW        = FRAC + 1;
  localparam int LANES     = 4;
  localparam int REG_IW    = 1;

  localparam logic [REG_IW-1:0] REG_LEN = 1'd0;
  localparam logic [REG_IW-1:0] REG_TOL = 1'd1;
  localparam logic [15:0]       TOL_RESET = 16'd16;

  localparam int LN_S1 = 0;
  localparam int LN_S2 = 1;
  localparam int LN_UX = 2;
  localparam int LN_UY = 3;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [31:0]        body1_mass;
    logic [31:0]        body2_mass;
  } in_t;

  typedef struct packed {
    logic signed [31:0] first_push_x;
    logic signed [31:0] first_push_y;
    logic signed [31:0] second_push_x;
    logic signed [31:0] second_push_y;
    logic signed [31:0] first_new_x;
    logic signed [31:0] first_new_y;
    logic signed [31:0] second_new_x;
    logic signed [31:0] second_new_y;
    logic               applied;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        m1;
    logic [31:0]        m2;
    logic [32:0]        msum;
    logic               dxp;
    logic               dxn;
    logic               dyp;
    logic               dyn;
    logic               taut;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [32:0]        m;
    logic               dxp;
    logic               dxn;
    logic               dyp;
    logic               dyn;
    logic               taut;
  } dv_side_t;

  typedef struct packed {
    logic [31:0] num;
    logic [32:0] den;
  } dv_lane_t;

  typedef dv_lane_t [LANES-1:0] dv_lanes_t;
  typedef logic [QW-1:0] quo_t;
  typedef quo_t [LANES-1:0] quos_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ccc_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on ccc_pkg.
module ccc_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [64:0]         d2,
  input  ccc_pkg::sq_side_t   in_side,
  output logic                out_valid,
  output logic [32:0]         root,
  output ccc_pkg::sq_side_t   out_side
);

  typedef struct packed {
    logic [65:0]       val;
    logic [35:0]       rem;
    logic [32:0]       root;
    ccc_pkg::sq_side_t side;
  } sq_st_t;

  logic   [ccc_pkg::SQ_STEPS-1:0] v;
  sq_st_t st [ccc_pkg::SQ_STEPS];

  for (genvar k = 0; k < ccc_pkg::SQ_STEPS; k++) begin : g_step
    localparam int B = 2 * (ccc_pkg::SQ_STEPS - 1 - k);
    sq_st_t      src;
    sq_st_t      nxt;
    logic        vin;
    logic [35:0] t;
    logic [34:0] trial;

    always_comb begin
      if (k == 0) begin
        src.val  = {1'b0, d2};
        src.rem  = '0;
        src.root = '0;
        src.side = in_side;
        vin      = in_valid;
      end else begin
        src = st[(k == 0) ? 0 : k-1];
        vin = v[(k == 0) ? 0 : k-1];
      end
      t     = {src.rem[33:0], src.val[B +: 2]};
      trial = {src.root, 2'b01};
      nxt   = src;
      if (t >= {1'b0, trial}) begin
        nxt.rem  = t - {1'b0, trial};
        nxt.root = {src.root[31:0], 1'b1};
      end else begin
        nxt.rem  = t;
        nxt.root = {src.root[31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid = v[ccc_pkg::SQ_STEPS-1];
  assign root      = st[ccc_pkg::SQ_STEPS-1].root;
  assign out_side  = st[ccc_pkg::SQ_STEPS-1].side;

endmodule

/* rtl/ccc_div.sv */
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Each lane divides num << FRAC by den where the quotient fits QW bits. Depends on ccc_pkg.
module ccc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ccc_pkg::dv_lanes_t lanes,
  input  ccc_pkg::dv_side_t  in_side,
  output logic               out_valid,
  output ccc_pkg::quos_t     quo,
  output ccc_pkg::dv_side_t  out_side
);

  typedef struct packed {
    logic [32:0]      rem;
    ccc_pkg::quo_t    q;
    logic [32:0]      den;
  } dv_ln_st_t;

  typedef struct packed {
    dv_ln_st_t [ccc_pkg::LANES-1:0] ln;
    ccc_pkg::dv_side_t              side;
  } dv_st_t;

  logic   [ccc_pkg::QW-1:0] v;
  dv_st_t st [ccc_pkg::QW];

  for (genvar k = 0; k < ccc_pkg::QW; k++) begin : g_step
    dv_st_t src;
    dv_st_t nxt;
    logic   vin;
    logic [ccc_pkg::LANES-1:0] nbit;

    always_comb begin
      if (k == 0) begin
        for (int i = 0; i < ccc_pkg::LANES; i++) begin
          // The top bits of the dividend are known to stay below the divisor.
          src.ln[i].rem = {2'b00, lanes[i].num[31:1]};
          src.ln[i].q   = '0;
          src.ln[i].den = lanes[i].den;
          nbit[i]       = lanes[i].num[0];
        end
        src.side = in_side;
        vin      = in_valid;
      end else begin
        src  = st[(k == 0) ? 0 : k-1];
        vin  = v[(k == 0) ? 0 : k-1];
        nbit = '0;
      end
      nxt = src;
      for (int i = 0; i < ccc_pkg::LANES; i++) begin
        if ({src.ln[i].rem, nbit[i]} >= {1'b0, src.ln[i].den}) begin
          nxt.ln[i].rem = 33'({src.ln[i].rem, nbit[i]} - {1'b0, src.ln[i].den});
          nxt.ln[i].q   = {src.ln[i].q[ccc_pkg::QW-2:0], 1'b1};
        end else begin
          nxt.ln[i].rem = {src.ln[i].rem[31:0], nbit[i]};
          nxt.ln[i].q   = {src.ln[i].q[ccc_pkg::QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ccc_pkg::LANES; i++) begin
      quo[i] = st[ccc_pkg::QW-1].ln[i].q;
    end
  end

  assign out_valid = v[ccc_pkg::QW-1];
  assign out_side  = st[ccc_pkg::QW-1].side;

endmodule

/* rtl/cable_constraint_correction.sv */
// Top level of the cable constraint correction pipeline.
// Depends on ccc_pkg, ccc_sqrt and ccc_div.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+--------------------------
//  in      | in        | in_valid / in_stall  | ccc_pkg::in_t
//  out     | out       | out_valid / out_stall| ccc_pkg::out_t
//  wr      | in        | wr_en                | wr_index, wr_data
//
// One beat may enter every cycle while the output is not stalled; its result is
// presented on out_data once it has passed the 33-stage square root, the
// 17-stage divider lanes and the registered stages around them.
// Reset clears every stage valid bit and loads the register defaults.
// A stalled output freezes the whole pipeline, so in_stall follows it.
module cable_constraint_correction (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ccc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ccc_pkg::out_t              out_data,
  input  logic                       wr_en,
  input  logic [ccc_pkg::REG_IW-1:0] wr_index,
  input  logic [30:0]                wr_data
);

  logic        en;
  logic [30:0] max_len;
  logic [15:0] equal_tolerance;
  logic [61:0] len_sq;
  logic [63:0] limit;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len         <= '0;
      equal_tolerance <= ccc_pkg::TOL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ccc_pkg::REG_LEN: max_len         <= wr_data;
        ccc_pkg::REG_TOL: equal_tolerance <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    len_sq <= max_len * max_len;
    limit  <= {2'b00, len_sq} + {32'b0, equal_tolerance, 16'b0};
  end

  // Stage 1: coordinate differences.
  logic               v1;
  ccc_pkg::in_t       in1;
  logic signed [32:0] dx1;
  logic signed [32:0] dy1;

  // Stage 2: magnitudes, mass sum and direction flags.
  logic              v2;
  ccc_pkg::sq_side_t side2;

  // Stage 3: squares.
  logic              v3;
  ccc_pkg::sq_side_t side3;
  logic [63:0]       sx3;
  logic [63:0]       sy3;

  // Stage 4: squared distance.
  logic              v4;
  ccc_pkg::sq_side_t side4;
  logic [64:0]       d2_4;

  logic [32:0] absx;
  logic [32:0] absy;

  assign absx = dx1[32] ? 33'(-dx1) : dx1;
  assign absy = dy1[32] ? 33'(-dy1) : dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1 <= in_data;
      dx1 <= {in_data.first_x[31], in_data.first_x} - {in_data.second_x[31], in_data.second_x};
      dy1 <= {in_data.first_y[31], in_data.first_y} - {in_data.second_y[31], in_data.second_y};

      side2.x1   <= in1.first_x;
      side2.y1   <= in1.first_y;
      side2.x2   <= in1.second_x;
      side2.y2   <= in1.second_y;
      side2.ax   <= absx[31:0];
      side2.ay   <= absy[31:0];
      side2.m1   <= in1.body1_mass;
      side2.m2   <= in1.body2_mass;
      side2.msum <= {1'b0, in1.body1_mass} + {1'b0, in1.body2_mass};
      side2.dxp  <= !dx1[32] && (dx1 != '0);
      side2.dxn  <= dx1[32];
      side2.dyp  <= !dy1[32] && (dy1 != '0);
      side2.dyn  <= dy1[32];
      side2.taut <= 1'b0;

      side3 <= side2;
      sx3   <= side2.ax * side2.ax;
      sy3   <= side2.ay * side2.ay;

      side4 <= side3;
      d2_4  <= {1'b0, sx3} + {1'b0, sy3};
    end
  end

  ccc_pkg::sq_side_t sq_in_side;
  ccc_pkg::sq_side_t sq_side;
  logic              sq_v;
  logic [32:0]       root;

  always_comb begin
    sq_in_side      = side4;
    sq_in_side.taut = (d2_4 > {1'b0, limit}) && (side4.msum > {17'b0, equal_tolerance});
  end

  ccc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .d2        (d2_4),
    .in_side   (sq_in_side),
    .out_valid (sq_v),
    .root      (root),
    .out_side  (sq_side)
  );

  ccc_pkg::dv_lanes_t dv_lanes;
  ccc_pkg::dv_side_t  dv_in_side;
  ccc_pkg::dv_side_t  dv_side;
  ccc_pkg::quos_t     quo;
  logic               dv_v;

  always_comb begin
    dv_lanes[ccc_pkg::LN_S1].num = sq_side.m1;
    dv_lanes[ccc_pkg::LN_S1].den = sq_side.msum;
    dv_lanes[ccc_pkg::LN_S2].num = sq_side.m2;
    dv_lanes[ccc_pkg::LN_S2].den = sq_side.msum;
    dv_lanes[ccc_pkg::LN_UX].num = sq_side.ax;
    dv_lanes[ccc_pkg::LN_UX].den = root;
    dv_lanes[ccc_pkg::LN_UY].num = sq_side.ay;
    dv_lanes[ccc_pkg::LN_UY].den = root;
    dv_in_side.x1   = sq_side.x1;
    dv_in_side.y1   = sq_side.y1;
    dv_in_side.x2   = sq_side.x2;
    dv_in_side.y2   = sq_side.y2;
    // A taut cable has a root no shorter than the cable, so this never wraps.
    dv_in_side.m    = root - {2'b00, max_len};
    dv_in_side.dxp  = sq_side.dxp;
    dv_in_side.dxn  = sq_side.dxn;
    dv_in_side.dyp  = sq_side.dyp;
    dv_in_side.dyn  = sq_side.dyn;
    dv_in_side.taut = sq_side.taut;
  end

  ccc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .lanes     (dv_lanes),
    .in_side   (dv_in_side),
    .out_valid (dv_v),
    .quo       (quo),
    .out_side  (dv_side)
  );

  // Stage M1: correction magnitudes per body.
  logic              v5;
  ccc_pkg::dv_side_t side5;
  ccc_pkg::quo_t     ux5;
  ccc_pkg::quo_t     uy5;
  logic [32:0]       mag1;
  logic [32:0]       mag2;
  logic [49:0]       pm1;
  logic [49:0]       pm2;

  assign pm1 = dv_side.m * quo[ccc_pkg::LN_S1];
  assign pm2 = dv_side.m * quo[ccc_pkg::LN_S2];

  // Stage M2: unsigned impulse components.
  logic              v6;
  ccc_pkg::dv_side_t side6;
  logic [33:0]       c1x;
  logic [33:0]       c1y;
  logic [33:0]       c2x;
  logic [33:0]       c2y;
  logic [49:0]       pc1x;
  logic [49:0]       pc1y;
  logic [49:0]       pc2x;
  logic [49:0]       pc2y;

  assign pc1x = ux5 * mag1;
  assign pc1y = uy5 * mag1;
  assign pc2x = ux5 * mag2;
  assign pc2y = uy5 * mag2;

  // Stage M3: signed, saturated impulses.
  logic               v7;
  ccc_pkg::dv_side_t  side7;
  logic signed [31:0] p1x;
  logic signed [31:0] p1y;
  logic signed [31:0] p2x;
  logic signed [31:0] p2y;

  function automatic logic signed [31:0] signed_push(input logic [33:0] c, input logic neg,
                                                      input logic taut);
    logic signed [35:0] e;
    logic signed [31:0] r;
    e = $signed({2'b00, c});
    if (!taut) begin
      r = '0;
    end else if (neg) begin
      r = ccc_pkg::sat32(-e);
    end else begin
      r = ccc_pkg::sat32(e);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= dv_v;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= dv_side;
      ux5   <= quo[ccc_pkg::LN_UX];
      uy5   <= quo[ccc_pkg::LN_UY];
      mag1  <= pm1[48:16];
      mag2  <= pm2[48:16];

      side6 <= side5;
      c1x   <= pc1x[49:16];
      c1y   <= pc1y[49:16];
      c2x   <= pc2x[49:16];
      c2y   <= pc2y[49:16];

      side7 <= side6;
      p1x   <= signed_push(c1x, side6.dxp, side6.taut);
      p1y   <= signed_push(c1y, side6.dyp, side6.taut);
      p2x   <= signed_push(c2x, side6.dxn, side6.taut);
      p2y   <= signed_push(c2y, side6.dyn, side6.taut);

      out_data.first_push_x  <= p1x;
      out_data.first_push_y  <= p1y;
      out_data.second_push_x <= p2x;
      out_data.second_push_y <= p2y;
      out_data.first_new_x   <= ccc_pkg::sat32(36'(side7.x1) + 36'(p1x));
      out_data.first_new_y   <= ccc_pkg::sat32(36'(side7.y1) + 36'(p1y));
      out_data.second_new_x  <= ccc_pkg::sat32(36'(side7.x2) + 36'(p2x));
      out_data.second_new_y  <= ccc_pkg::sat32(36'(side7.y2) + 36'(p2y));
      out_data.applied       <= side7.taut;
    end
  end

endmodule
